/* rtl/clnws_pkg.sv */
// Types, codes and constants shared by the character LCD write sequencer.
package clnws_pkg;

    typedef enum logic [2:0] {
        ACT_CMD    = 3'd0,
        ACT_DATA   = 3'd1,
        ACT_CURSOR = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_INIT   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        CFG_ENABLE_PULSE = 2'd0,
        CFG_SETTLE       = 2'd1,
        CFG_POWER_UP     = 2'd2,
        CFG_CLEAR_EXTRA  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POWER,
        ST_BYTE
    } state_t;

    typedef enum logic [1:0] {
        SEG_UPPER_HI = 2'd0,
        SEG_UPPER_LO = 2'd1,
        SEG_LOWER_HI = 2'd2,
        SEG_LOWER_LO = 2'd3
    } seg_t;

    localparam logic [7:0] CMD_FUNCSET = 8'h28;
    localparam logic [7:0] CMD_DISPLAY = 8'h0C;
    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] CMD_ENTRY   = 8'h06;
    localparam logic [7:0] CMD_DDRAM   = 8'h80;
    localparam logic [7:0] ROW1_BASE   = 8'h40;
    localparam logic [3:0] NIB_MASK    = 4'hF;

    localparam logic [1:0] INIT_LAST_BYTE  = 2'd3;
    localparam logic [1:0] INIT_CLEAR_BYTE = 2'd2;

    localparam logic [7:0] RESET_ENABLE_PULSE = 8'd1;
    localparam logic [7:0] RESET_SETTLE       = 8'd2;
    localparam logic [7:0] RESET_POWER_UP     = 8'd20;
    localparam logic [7:0] RESET_CLEAR_EXTRA  = 8'd2;

    typedef struct packed {
        logic       load;
        logic       issue;
        logic       power;
        logic [1:0] byte_idx;
        seg_t       seg;
        logic       last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_ok;
        logic in_init;
        logic out_free;
    } dp_status_t;

    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = CMD_FUNCSET;
            2'd1:    b = CMD_DISPLAY;
            2'd2:    b = CMD_CLEAR;
            default: b = CMD_ENTRY;
        endcase
        return b;
    endfunction

endpackage

/* rtl/clnws_ctrl.sv */
// Controller state machine that steps through the segments of one request.
module clnws_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  clnws_pkg::dp_status_t status,
    output clnws_pkg::ctrl_cmd_t  cmd
);

    clnws_pkg::state_t state_reg, state_next;
    logic              init_reg, init_next;
    logic [1:0]        byte_idx_reg, byte_idx_next;
    clnws_pkg::seg_t   seg_reg, seg_next;
    logic              byte_last;

    assign byte_last = init_reg ? (byte_idx_reg == clnws_pkg::INIT_LAST_BYTE) : 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= clnws_pkg::ST_IDLE;
            init_reg     <= 1'b0;
            byte_idx_reg <= '0;
            seg_reg      <= clnws_pkg::SEG_UPPER_HI;
        end else begin
            state_reg    <= state_next;
            init_reg     <= init_next;
            byte_idx_reg <= byte_idx_next;
            seg_reg      <= seg_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        init_next     = init_reg;
        byte_idx_next = byte_idx_reg;
        seg_next      = seg_reg;
        case (state_reg)
            clnws_pkg::ST_IDLE: begin
                byte_idx_next = '0;
                seg_next      = clnws_pkg::SEG_UPPER_HI;
                if (s_valid && status.in_ok) begin
                    init_next  = status.in_init;
                    state_next = status.in_init ? clnws_pkg::ST_POWER : clnws_pkg::ST_BYTE;
                end
            end
            clnws_pkg::ST_POWER: begin
                if (status.out_free) begin
                    state_next = clnws_pkg::ST_BYTE;
                end
            end
            clnws_pkg::ST_BYTE: begin
                if (status.out_free) begin
                    if (seg_reg == clnws_pkg::SEG_LOWER_LO) begin
                        seg_next = clnws_pkg::SEG_UPPER_HI;
                        if (byte_last) begin
                            state_next = clnws_pkg::ST_IDLE;
                        end else begin
                            byte_idx_next = byte_idx_reg + 2'd1;
                        end
                    end else begin
                        seg_next = clnws_pkg::seg_t'(seg_reg + 2'd1);
                    end
                end
            end
            default: begin
                state_next = clnws_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd.load     = 1'b0;
        cmd.issue    = 1'b0;
        cmd.power    = 1'b0;
        cmd.byte_idx = byte_idx_reg;
        cmd.seg      = seg_reg;
        cmd.last     = 1'b0;
        case (state_reg)
            clnws_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid && status.in_ok;
            end
            clnws_pkg::ST_POWER: begin
                cmd.issue = status.out_free;
                cmd.power = 1'b1;
            end
            clnws_pkg::ST_BYTE: begin
                cmd.issue = status.out_free;
                cmd.last  = (seg_reg == clnws_pkg::SEG_LOWER_LO) && byte_last;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/clnws_dp.sv */
// Datapath: timing registers, request capture, segment build and output register.
module clnws_dp #(
    parameter int COLUMNS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic [2:0]            s_action,
    input  logic [7:0]            s_byte_value,
    input  logic [1:0]            s_row,
    input  logic [4:0]            s_col,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_reg_select,
    output logic [3:0]            m_data_nibble,
    output logic                  m_enable,
    output logic [8:0]            m_hold_ms,
    output logic                  m_last,
    input  clnws_pkg::ctrl_cmd_t  cmd,
    output clnws_pkg::dp_status_t status
);

    localparam logic [5:0] COL_LIMIT = 6'(COLUMNS);

    logic [7:0] enable_pulse_reg, settle_reg, power_up_reg, clear_extra_reg;

    logic [7:0] byte_reg, byte_next;
    logic       rs_reg, rs_next;
    logic       clear_reg, clear_next;
    logic       init_reg, init_next;

    logic       m_valid_reg, m_valid_next;
    logic       rs_out_reg, rs_out_next;
    logic [3:0] nib_reg, nib_next;
    logic       en_reg, en_next;
    logic [8:0] hold_reg, hold_next;
    logic       last_reg, last_next;

    logic [7:0] in_byte;
    logic [7:0] cur_byte;
    logic       use_extra;
    logic [7:0] extra;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_pulse_reg <= clnws_pkg::RESET_ENABLE_PULSE;
            settle_reg       <= clnws_pkg::RESET_SETTLE;
            power_up_reg     <= clnws_pkg::RESET_POWER_UP;
            clear_extra_reg  <= clnws_pkg::RESET_CLEAR_EXTRA;
        end else if (cfg_valid) begin
            case (clnws_pkg::cfg_idx_t'(cfg_index))
                clnws_pkg::CFG_ENABLE_PULSE: enable_pulse_reg <= cfg_data;
                clnws_pkg::CFG_SETTLE:       settle_reg       <= cfg_data;
                clnws_pkg::CFG_POWER_UP:     power_up_reg     <= cfg_data;
                clnws_pkg::CFG_CLEAR_EXTRA:  clear_extra_reg  <= cfg_data;
                default:                     clear_extra_reg  <= clear_extra_reg;
            endcase
        end
    end

    // Decode the incoming request and check it.
    always_comb begin
        status.in_ok    = 1'b0;
        status.in_init  = (s_action == clnws_pkg::ACT_INIT);
        status.out_free = !m_valid_reg || m_ready;
        in_byte         = s_byte_value;
        case (s_action)
            clnws_pkg::ACT_CMD, clnws_pkg::ACT_DATA, clnws_pkg::ACT_INIT: begin
                status.in_ok = 1'b1;
            end
            clnws_pkg::ACT_CURSOR: begin
                status.in_ok = (s_row inside {2'd0, 2'd1}) && ({1'b0, s_col} < COL_LIMIT);
                in_byte      = clnws_pkg::CMD_DDRAM
                             | (s_row[0] ? clnws_pkg::ROW1_BASE : 8'h00)
                             | {3'b000, s_col};
            end
            clnws_pkg::ACT_CLEAR: begin
                status.in_ok = 1'b1;
                in_byte      = clnws_pkg::CMD_CLEAR;
            end
            default: begin
                status.in_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        byte_next  = byte_reg;
        rs_next    = rs_reg;
        clear_next = clear_reg;
        init_next  = init_reg;
        if (cmd.load) begin
            byte_next  = in_byte;
            rs_next    = (s_action == clnws_pkg::ACT_DATA);
            clear_next = (s_action == clnws_pkg::ACT_CLEAR);
            init_next  = status.in_init;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        rs_reg    <= rs_next;
        clear_reg <= clear_next;
        init_reg  <= init_next;
    end

    assign cur_byte  = init_reg ? clnws_pkg::init_byte(cmd.byte_idx) : byte_reg;
    assign use_extra = clear_reg || (init_reg && (cmd.byte_idx == clnws_pkg::INIT_CLEAR_BYTE));
    assign extra     = use_extra ? clear_extra_reg : 8'h00;

    // Build the next segment.
    always_comb begin
        rs_out_next = rs_out_reg;
        nib_next    = nib_reg;
        en_next     = en_reg;
        hold_next   = hold_reg;
        last_next   = last_reg;
        if (cmd.issue) begin
            last_next = cmd.last;
            if (cmd.power) begin
                rs_out_next = 1'b0;
                nib_next    = 4'h0;
                en_next     = 1'b0;
                hold_next   = {1'b0, power_up_reg};
            end else begin
                rs_out_next = rs_reg;
                case (cmd.seg)
                    clnws_pkg::SEG_UPPER_HI: begin
                        nib_next  = cur_byte[7:4] & clnws_pkg::NIB_MASK;
                        en_next   = 1'b1;
                        hold_next = {1'b0, enable_pulse_reg};
                    end
                    clnws_pkg::SEG_UPPER_LO: begin
                        nib_next  = cur_byte[7:4] & clnws_pkg::NIB_MASK;
                        en_next   = 1'b0;
                        hold_next = 9'd0;
                    end
                    clnws_pkg::SEG_LOWER_HI: begin
                        nib_next  = cur_byte[3:0] & clnws_pkg::NIB_MASK;
                        en_next   = 1'b1;
                        hold_next = {1'b0, enable_pulse_reg};
                    end
                    default: begin
                        nib_next  = cur_byte[3:0] & clnws_pkg::NIB_MASK;
                        en_next   = 1'b0;
                        hold_next = {1'b0, settle_reg} + {1'b0, extra};
                    end
                endcase
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.issue) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rs_out_reg <= rs_out_next;
        nib_reg    <= nib_next;
        en_reg     <= en_next;
        hold_reg   <= hold_next;
        last_reg   <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_reg_select  = rs_out_reg;
    assign m_data_nibble = nib_reg;
    assign m_enable      = en_reg;
    assign m_hold_ms     = hold_reg;
    assign m_last        = last_reg;

endmodule

/* rtl/char_lcd_nibble_write_sequencer.sv */
// Top level of the character LCD 4-bit write sequencer.
// Each accepted request becomes a list of pin segments (register select, D4..D7, enable,
// hold in ms) for an LCD on a 4-bit bus, one segment per cycle while m_ready is high. A
// command, data, cursor or clear request gives 4 segments and init gives 17; the request
// is taken in ST_IDLE and the controller then walks the segments, so no new request is
// taken until the last segment of the current one is issued. Requests with an unknown
// action or an out-of-range cursor are taken and dropped. Timing registers are written
// through the cfg port, which is always ready; write them only while the block is idle.
module char_lcd_nibble_write_sequencer #(
    parameter int COLUMNS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_action,
    input  logic [7:0] s_byte_value,
    input  logic [1:0] s_row,
    input  logic [4:0] s_col,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_reg_select,
    output logic [3:0] m_data_nibble,
    output logic       m_enable,
    output logic [8:0] m_hold_ms,
    output logic       m_last
);

    clnws_pkg::ctrl_cmd_t  cmd;
    clnws_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    clnws_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    clnws_dp #(
        .COLUMNS (COLUMNS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_action      (s_action),
        .s_byte_value  (s_byte_value),
        .s_row         (s_row),
        .s_col         (s_col),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_reg_select  (m_reg_select),
        .m_data_nibble (m_data_nibble),
        .m_enable      (m_enable),
        .m_hold_ms     (m_hold_ms),
        .m_last        (m_last),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

/* rtl/clnws_chk.sv */
// Port checker for the character LCD write sequencer, bound to the top level.
module clnws_chk (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [2:0] s_action,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_reg_select,
    input logic [3:0] m_data_nibble,
    input logic       m_enable,
    input logic [8:0] m_hold_ms,
    input logic       m_last
);

    // Hold a stalled word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_nibble) && $stable(m_hold_ms)
            && $stable(m_enable) && $stable(m_last) && $stable(m_reg_select))
        else $error("stalled result word changed");

    // Drop ready after taking a byte write request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready
            && (s_action == clnws_pkg::ACT_CMD || s_action == clnws_pkg::ACT_DATA)
            |=> !s_ready)
        else $error("new request taken while a byte is in progress");

    // End every request on an enable-low segment.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> !m_enable)
        else $error("last segment with enable high");

    // Enable-high segments carry only the pulse time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_enable |-> !m_hold_ms[8])
        else $error("enable-high hold out of range");

endmodule

bind char_lcd_nibble_write_sequencer clnws_chk u_clnws_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_action      (s_action),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_reg_select  (m_reg_select),
    .m_data_nibble (m_data_nibble),
    .m_enable      (m_enable),
    .m_hold_ms     (m_hold_ms),
    .m_last        (m_last)
);
